// ===== design/rap_pkg.sv =====
package rap_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int EXP_TABLE_BITS = 10;
  localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;

  // register indexes
  localparam logic [2:0] REG_INITIAL_FLUX      = 3'd0;
  localparam logic [2:0] REG_INV_HYDROGEN_MASS = 3'd1;
  localparam logic [2:0] REG_ABSORB_LENGTH     = 3'd2;
  localparam logic [2:0] REG_INV_CELL_LENGTH   = 3'd3;
  localparam logic [2:0] REG_MIN_FRACTION      = 3'd4;

  typedef logic [30:0] exp_tbl_t [EXP_SIZE];

  typedef struct packed {
    logic [31:0] initial_flux;
    logic [31:0] inv_hydrogen_mass;
    logic [31:0] absorb_length;
    logic [31:0] inv_cell_length;
    logic [15:0] min_fraction;
  } cfg_t;

  // one classified cell between the front and back parts
  typedef struct packed {
    logic        first_of_ray;
    logic [31:0] prior_rate;
    logic [31:0] n_h;
    logic [30:0] eq;
  } cell_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != '0) ? MAX32 : v[31:0];
  endfunction

  // floor square root, used only while the table is built
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int k = 0; k < 32; k++) begin
      if (b != '0) begin
        if (b <= x) begin
          if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end else if (r != '0) begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    isqrt64 = r;
  endfunction

  // exp(-k / 2^T * ln 2) in Q1.30, power-of-two steps
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    t;
    logic [63:0] r;
    logic [63:0] p;
    r = 64'd1 << 29;
    for (int m = 0; m < EXP_TABLE_BITS; m++) r = isqrt64(r << 30);
    t[0] = ONE_Q30;
    for (int m = 1; m < EXP_SIZE; m++) begin
      p = 64'(t[m-1]) * r + (64'd1 << 29);
      t[m] = p[60:30];
    end
    build_exp_tbl = t;
  endfunction

endpackage

// ===== design/rap_if.sv =====
interface rap_in_if;
  logic        valid;
  logic        ready;
  logic        first_of_ray;
  logic [31:0] density;
  logic [31:0] prior_rate;
  modport source (output valid, first_of_ray, density, prior_rate, input ready);
  modport sink (input valid, first_of_ray, density, prior_rate, output ready);
endinterface

interface rap_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_rate;
  logic        ray_ended;
  logic [31:0] exit_flux;
  modport source (output valid, new_rate, ray_ended, exit_flux, input ready);
  modport sink (input valid, new_rate, ray_ended, exit_flux, output ready);
endinterface

interface rap_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rap_front.sv =====
module rap_front
  import rap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  rap_in_if.sink      cells,
  output logic        push,
  output cell_t       push_item,
  input  logic        full
);

  localparam int YSH = FRAC_BITS + 30;
  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  logic        v1, v2, v3, v4, v5;
  logic        f1, f2, f3, f4, f5;
  logic [31:0] r1, r2, r3, r4, r5;
  logic [63:0] p1, p2;
  logic [31:0] nh2, nh3, nh4, nh5;
  logic [62:0] y3;
  logic [30:0] rom4, eq5;
  logic [4:0]  ip4;
  logic        big4;
  logic        en;
  logic [31:0] nh_c, tau_c;
  logic [62:0] ip_full;

  // whole pipe moves unless the last stage is blocked
  assign en          = !v5 || !full;
  assign cells.ready = en;
  assign push        = v5 && !full;
  assign push_item   = '{first_of_ray: f5, prior_rate: r5, n_h: nh5, eq: eq5};

  assign nh_c    = sat32(p1 >> FRAC_BITS);
  assign tau_c   = sat32(p2 >> FRAC_BITS);
  assign ip_full = y3 >> YSH;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else if (en) begin
      v1 <= cells.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // number density, optical depth, exponent split, table read, scale
  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= 64'(cells.density) * 64'(cfg.inv_hydrogen_mass);
      f1   <= cells.first_of_ray;
      r1   <= cells.prior_rate;
      nh2  <= nh_c;
      p2   <= 64'(nh_c) * 64'(cfg.absorb_length);
      f2   <= f1;
      r2   <= r1;
      y3   <= 63'(tau_c) * 63'(LOG2E_Q30);
      nh3  <= nh2;
      f3   <= f2;
      r3   <= r2;
      rom4 <= EXP_TBL[y3[YSH-1 -: EXP_TABLE_BITS]];
      big4 <= (ip_full >= 63'd31);
      ip4  <= ip_full[4:0];
      nh4  <= nh3;
      f4   <= f3;
      r4   <= r3;
      eq5  <= big4 ? '0 : (rom4 >> ip4);
      nh5  <= nh4;
      f5   <= f4;
      r5   <= r4;
    end
  end

endmodule

// ===== design/rap_queue.sv =====
module rap_queue
  import rap_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cell_t push_item,
  output logic  full,
  input  logic  pop,
  output cell_t head,
  output logic  empty
);

  cell_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// ===== design/rap_back.sv =====
module rap_back
  import rap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cell_t       head,
  input  logic        empty,
  output logic        pop,
  rap_out_if.source   rates
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_M3   = 3'd4;
  localparam logic [2:0] S_M4   = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]  state;
  logic [31:0] running_flux;
  logic        stopped;
  logic [31:0] nh, prior, flux_next, kph;
  logic [30:0] eq;
  logic        byp, zero;
  logic [31-FRAC_BITS:0] t_hi;
  logic [63:0] lo, prod, quo;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic [47:0] thr;
  logic [31:0] mul_x, mul_y;
  logic [79:0] sum;
  logic [32:0] r2;
  logic        out_free;
  logic [32:0] rate_sum;
  logic        stop;

  assign out_free = !rates.valid || rates.ready;
  assign pop      = (state == S_IDLE) && !empty;
  assign sum      = 80'(lo) + {prod[47:0], 32'b0};
  assign r2       = {rem, quo[63]};
  assign rate_sum = 33'(prior) + 33'(kph);
  assign stop     = {flux_next, 16'b0} < thr;

  // shared multiplier operands
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      S_LOAD: begin
        mul_x = running_flux;
        mul_y = 32'(eq);
      end
      S_M1: begin
        mul_x = running_flux;
        mul_y = zero ? cfg.absorb_length : 32'(ONE_Q30 - eq);
      end
      S_M2: begin
        mul_x = zero ? prod[FRAC_BITS+31:FRAC_BITS] : prod[61:30];
        mul_y = cfg.inv_cell_length;
      end
      S_M3: begin
        mul_x = 32'(t_hi);
        mul_y = cfg.inv_cell_length;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_x) * 64'(mul_y);
    thr  <= 48'(cfg.initial_flux) * 48'(cfg.min_fraction);
  end

  // sequencer for one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_flux <= '0;
      stopped      <= 1'b0;
      rates.valid  <= 1'b0;
    end else begin
      // result valid set on issue, cleared once taken
      if (state == S_FIN && out_free) rates.valid <= 1'b1;
      else if (rates.ready) rates.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            if (head.first_of_ray) begin
              running_flux <= cfg.initial_flux;
              stopped      <= 1'b0;
            end
            byp   <= stopped && !head.first_of_ray;
            zero  <= (head.n_h == '0);
            nh    <= head.n_h;
            eq    <= head.eq;
            prior <= head.prior_rate;
            state <= (stopped && !head.first_of_ray) ? S_FIN : S_LOAD;
          end
        end
        S_LOAD: state <= S_M1;
        S_M1: begin
          flux_next <= prod[61:30];
          state     <= S_M2;
        end
        S_M2: begin
          t_hi  <= prod[63:FRAC_BITS+32];
          state <= S_M3;
        end
        S_M3: begin
          if (zero) begin
            lo    <= prod;
            state <= S_M4;
          end else begin
            quo   <= prod;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_M4: begin
          kph   <= (sum[79:FRAC_BITS+32] != '0) ? MAX32 : sum[FRAC_BITS+31:FRAC_BITS];
          state <= S_FIN;
        end
        S_DIV: begin
          // one restoring step per cycle
          if (r2 >= 33'(nh)) begin
            rem <= 32'(r2 - 33'(nh));
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= r2[31:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            if (byp) begin
              rates.new_rate  <= prior;
              rates.ray_ended <= 1'b1;
              rates.exit_flux <= '0;
            end else begin
              rates.new_rate  <= rate_sum[32] ? MAX32 : rate_sum[31:0];
              rates.ray_ended <= stop;
              rates.exit_flux <= stop ? '0 : flux_next;
              running_flux    <= stop ? '0 : flux_next;
              if (stop) stopped <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // divider result, saturated
      if (state == S_DIV && cnt == 6'd63) begin
        kph <= (quo[62:31] != '0) ? MAX32 : {quo[30:0], r2 >= 33'(nh)};
      end
    end
  end

endmodule

// ===== design/ray_attenuation_photo_rate.sv =====
// channel   role  payload
// cells     sink  first_of_ray, density, prior_rate
// rates     src   new_rate, ray_ended, exit_flux
// cfg       sink  index, data (always ready)
//
// front pipe takes one cell a cycle while the queue has room, five stages to the queue
// back part: one cell at a time, summing products at zero density, dividing otherwise
// (64-step restoring divider, one shared 32x32 multiplier)
// a cell of a stopped ray skips the multiplies and the divider in the back part
// a full queue stalls the front pipe, a held result stalls the back
// synchronous reset clears flux, stop mark and all valids
module ray_attenuation_photo_rate
  import rap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rap_in_if.sink     cells,
  rap_out_if.source  rates,
  rap_cfg_if.sink    cfg
);

  cfg_t  regs;
  logic  push, full, pop, empty;
  cell_t push_item, head;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.initial_flux      <= 32'd65536;
      regs.inv_hydrogen_mass <= 32'd65536;
      regs.absorb_length     <= 32'd65536;
      regs.inv_cell_length   <= 32'd65536;
      regs.min_fraction      <= 16'd66;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_INITIAL_FLUX:      regs.initial_flux      <= cfg.data;
        REG_INV_HYDROGEN_MASS: regs.inv_hydrogen_mass <= cfg.data;
        REG_ABSORB_LENGTH:     regs.absorb_length     <= cfg.data;
        REG_INV_CELL_LENGTH:   regs.inv_cell_length   <= cfg.data;
        REG_MIN_FRACTION:      regs.min_fraction      <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  rap_front u_front (
    .clk(clk), .rst(rst), .cfg(regs), .cells(cells),
    .push(push), .push_item(push_item), .full(full)
  );

  rap_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  rap_back u_back (
    .clk(clk), .rst(rst), .cfg(regs), .head(head), .empty(empty),
    .pop(pop), .rates(rates)
  );

endmodule
